[hw/rtl/cmnc_pkg.sv]
// ============================================================================
// Change-mask compositor package
// Shared codes, field widths and reset constants.
// ============================================================================
package cmnc_pkg;

    localparam int PIX_W      = 8;    // palette index width
    localparam int CFG_DATA_W = 11;   // widest configuration register
    localparam int VW_CFG_W   = 10;   // viewport_width register width
    localparam int VH_CFG_W   = 11;   // viewport_height register width

    localparam int VW_RESET   = 360;
    localparam int VH_RESET   = 240;

    typedef enum logic [0:0] {
        CFG_VIEWPORT_WIDTH  = 1'b0,
        CFG_VIEWPORT_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

endpackage

[hw/rtl/cmnc_if.sv]
// ============================================================================
// Change-mask compositor channels
// Valid/ready channels for pixel items and for pixel decisions.
// ============================================================================
interface cmnc_pix_if;
    logic                       valid;
    logic                       ready;
    cmnc_pkg::op_t              op;
    logic [cmnc_pkg::PIX_W-1:0] cur_pixel;
    logic [cmnc_pkg::PIX_W-1:0] orig_pixel;

    modport source (output valid, op, cur_pixel, orig_pixel, input ready);
    modport sink   (input valid, op, cur_pixel, orig_pixel, output ready);
endinterface

interface cmnc_dec_if #(
    parameter int COL_W = 9,
    parameter int ROW_W = 10
);
    logic                       valid;
    logic                       ready;
    logic [cmnc_pkg::PIX_W-1:0] low_res_index;
    logic                       use_low_res;
    logic [COL_W-1:0]           column;
    logic [ROW_W-1:0]           row;
    logic                       frame_end;

    modport source (output valid, low_res_index, use_low_res, column, row, frame_end,
                    input ready);
    modport sink   (input valid, low_res_index, use_low_res, column, row, frame_end,
                    output ready);
endinterface

[hw/rtl/cmnc_line_mem.sv]
// ============================================================================
// Change-mask compositor line memory
// Pending-row store (two read ports) and above-row flag store, one write
// port each, registered reads, write-first on an address match.
// ============================================================================
module cmnc_line_mem #(
    parameter int DEPTH = 512
) (
    input  logic                         clk,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr0,
    input  logic [$clog2(DEPTH)-1:0]     raddr1,
    input  logic                         we_pend,
    input  logic                         we_above,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [cmnc_pkg::PIX_W:0]     wdata_pend,
    input  logic                         wdata_above,
    output logic [cmnc_pkg::PIX_W:0]     rdata_pend0,
    output logic [cmnc_pkg::PIX_W:0]     rdata_pend1,
    output logic                         rdata_above
);

    logic [cmnc_pkg::PIX_W:0] pend_mem [DEPTH];
    logic                     above_mem [DEPTH];

    // pending row: one write, two reads
    always_ff @(posedge clk)
    begin
        if (we_pend)
        begin
            pend_mem[waddr] <= wdata_pend;
        end
        if (re)
        begin
            if (we_pend && (waddr == raddr0))
            begin
                rdata_pend0 <= wdata_pend;
            end
            else
            begin
                rdata_pend0 <= pend_mem[raddr0];
            end
            if (we_pend && (waddr == raddr1))
            begin
                rdata_pend1 <= wdata_pend;
            end
            else
            begin
                rdata_pend1 <= pend_mem[raddr1];
            end
        end
    end

    // above-row flags: one write, one read
    always_ff @(posedge clk)
    begin
        if (we_above)
        begin
            above_mem[waddr] <= wdata_above;
        end
        if (re)
        begin
            if (we_above && (waddr == raddr0))
            begin
                rdata_above <= wdata_above;
            end
            else
            begin
                rdata_above <= above_mem[raddr0];
            end
        end
    end

endmodule

[hw/rtl/change_mask_neighbour_compositor_unit.sv]
// ============================================================================
// Change-mask neighbour compositor
// Marks changed pixels and decides low-res versus hi-res overlay per pixel,
// one row behind the incoming raster stream.
// ============================================================================
// Takes one pixel transaction per clock and returns one decision transaction
// per clock unless decisions stall. A pixel of row r is decided while row
// r+1 (or a flush transaction, for the last row) passes the same column;
// the decision is formed in stage 1 and held in the output register.
// Throughput is set by the line memory, which is read once and written once
// per cycle; back-to-back transactions of neighbouring columns are covered
// by write-first bypass in the memory, so there is no interlock bubble. The
// line memory has no clearing pass: it is usable right after reset, and the
// first row of each frame is only stored, never decided. Flush transactions
// must follow the last row, one per column; pixels arriving after a full
// frame and flushes arriving early are accepted and dropped. A register
// write restarts the frame and must only happen while the block is idle.
// ============================================================================
module change_mask_neighbour_compositor_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  cmnc_pkg::cfg_index_t              cfg_index,
    input  logic [cmnc_pkg::CFG_DATA_W-1:0]   cfg_data,
    cmnc_pix_if.sink                          pixels,
    cmnc_dec_if.source                        decisions
);

    localparam int AW = $clog2(MAX_WIDTH);        // column / memory address
    localparam int WW = $clog2(MAX_WIDTH + 1);    // viewport width value
    localparam int RW = $clog2(MAX_HEIGHT);       // decided row
    localparam int HW = $clog2(MAX_HEIGHT + 1);   // row counter / height
    localparam int PW = cmnc_pkg::PIX_W;

    localparam int W_RST = (cmnc_pkg::VW_RESET > MAX_WIDTH)  ? MAX_WIDTH  : cmnc_pkg::VW_RESET;
    localparam int H_RST = (cmnc_pkg::VH_RESET > MAX_HEIGHT) ? MAX_HEIGHT : cmnc_pkg::VH_RESET;

    typedef struct packed {
        logic op_flush;     // flush transaction, no pixel stored
        logic has_dec;      // a row above is pending: decide it
        logic up_masked;    // deciding the first row
        logic left_ok;      // column is not the first
        logic right_ok;     // column is not the last
        logic frame_end;    // last flush transaction of the frame
        logic wrap;         // last column of the row
    } stage_ctl_t;

    // ---------------- configuration ----------------
    logic [WW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [31:0]   vw_ext;
    logic [31:0]   vh_ext;
    logic [WW-1:0] w_cfg;
    logic [HW-1:0] h_cfg;

    // 0 reads as 1, oversize clamps to the maximum
    always_comb
    begin
        vw_ext = 32'(cfg_data[cmnc_pkg::VW_CFG_W-1:0]);
        vh_ext = 32'(cfg_data[cmnc_pkg::VH_CFG_W-1:0]);
        if (vw_ext == 32'd0)
        begin
            w_cfg = WW'(1);
        end
        else if (vw_ext > 32'(MAX_WIDTH))
        begin
            w_cfg = WW'(MAX_WIDTH);
        end
        else
        begin
            w_cfg = WW'(vw_ext);
        end
        if (vh_ext == 32'd0)
        begin
            h_cfg = HW'(1);
        end
        else if (vh_ext > 32'(MAX_HEIGHT))
        begin
            h_cfg = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_cfg = HW'(vh_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= WW'(W_RST);
            h_reg <= HW'(H_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cmnc_pkg::CFG_VIEWPORT_WIDTH:  w_reg <= w_cfg;
                cmnc_pkg::CFG_VIEWPORT_HEIGHT: h_reg <= h_cfg;
                default:                       w_reg <= w_reg;
            endcase
        end
    end

    // ---------------- intake / position counters ----------------
    logic [AW-1:0] col_count_reg, col_count_next;
    logic [HW-1:0] row_count_reg, row_count_next;
    logic [AW-1:0] col0;
    logic [WW-1:0] col_inc;
    logic          in_accept;
    logic          ignore;
    logic          take;
    logic          below;
    stage_ctl_t    ctl_new;

    // stage 1: item waiting on its memory read data
    logic          s1_valid_reg;
    stage_ctl_t    s1_ctl_reg;
    logic [PW-1:0] s1_cur_reg;
    logic          s1_below_reg;
    logic [AW-1:0] s1_col_reg;
    logic [RW-1:0] s1_drow_reg;
    logic          s1_adv;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_index_reg;
    logic          out_use_reg;
    logic [AW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic          out_end_reg;

    logic          left_flag_reg, left_flag_next;

    // memory read data
    logic [PW:0]   p_self;
    logic [PW:0]   p_right;
    logic          a_up;

    assign in_accept = pixels.valid && pixels.ready;
    assign pixels.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        col0    = (WW'(col_count_reg) >= w_reg) ? '0 : col_count_reg;
        col_inc = WW'(col0) + WW'(1);
        ignore  = ((pixels.op == cmnc_pkg::OP_PIXEL) && (row_count_reg >= h_reg))
               || ((pixels.op == cmnc_pkg::OP_FLUSH) && (row_count_reg < h_reg));
        take    = in_accept && !ignore;
        below   = (pixels.op == cmnc_pkg::OP_PIXEL) && (pixels.cur_pixel != pixels.orig_pixel);

        ctl_new.op_flush  = (pixels.op == cmnc_pkg::OP_FLUSH);
        ctl_new.has_dec   = (row_count_reg != '0);
        ctl_new.up_masked = (row_count_reg == HW'(1));
        ctl_new.left_ok   = (col0 != '0);
        ctl_new.right_ok  = (col_inc < w_reg);
        ctl_new.wrap      = (col_inc >= w_reg);
        ctl_new.frame_end = ctl_new.op_flush && ctl_new.wrap;

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_we)
        begin
            // any register write restarts the frame
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (take)
        begin
            if (ctl_new.wrap)
            begin
                col_count_next = '0;
                row_count_next = ctl_new.op_flush ? '0 : row_count_reg + HW'(1);
            end
            else
            begin
                col_count_next = AW'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ---------------- line memory ----------------
    logic          we_pend;
    logic          we_above;
    logic          use_dec;
    logic [2:0]    nb_count;
    logic          nb_left;
    logic          nb_right;
    logic          nb_up;

    // read self and right neighbour of the incoming column; the right read
    // past the last column is masked by right_ok
    cmnc_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .clk         (clk),
        .re          (take),
        .raddr0      (col0),
        .raddr1      (AW'(col_inc)),
        .we_pend     (we_pend),
        .we_above    (we_above),
        .waddr       (s1_col_reg),
        .wdata_pend  ({s1_below_reg, s1_cur_reg}),
        .wdata_above (p_self[PW]),
        .rdata_pend0 (p_self),
        .rdata_pend1 (p_right),
        .rdata_above (a_up)
    );

    // ---------------- stage 1: decide ----------------
    always_comb
    begin
        nb_left  = s1_ctl_reg.left_ok   && left_flag_reg;
        nb_right = s1_ctl_reg.right_ok  && p_right[PW];
        nb_up    = !s1_ctl_reg.up_masked && a_up;
        nb_count = 3'(nb_left) + 3'(nb_right) + 3'(nb_up) + 3'(s1_below_reg);
        use_dec  = p_self[PW] || (nb_count >= 3'd2);

        // a row-zero item only stores; a decision needs a free output slot
        s1_adv   = s1_valid_reg
                && (!s1_ctl_reg.has_dec || !out_valid_reg || decisions.ready);
        we_pend  = s1_adv && !s1_ctl_reg.op_flush;
        we_above = s1_adv && s1_ctl_reg.has_dec;

        left_flag_next = left_flag_reg;
        if (cfg_we)
        begin
            left_flag_next = 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_ctl_reg.wrap)
            begin
                left_flag_next = 1'b0;
            end
            else if (s1_ctl_reg.has_dec)
            begin
                left_flag_next = p_self[PW];
            end
        end

        out_valid_next = out_valid_reg;
        if (s1_adv && s1_ctl_reg.has_dec)
        begin
            out_valid_next = 1'b1;
        end
        else if (decisions.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_flag_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= take || (s1_valid_reg && !s1_adv);
            out_valid_reg <= out_valid_next;
            left_flag_reg <= left_flag_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_ctl_reg   <= ctl_new;
            s1_cur_reg   <= pixels.cur_pixel;
            s1_below_reg <= below;
            s1_col_reg   <= col0;
            s1_drow_reg  <= RW'(row_count_reg - HW'(1));
        end
        if (s1_adv && s1_ctl_reg.has_dec)
        begin
            out_index_reg <= p_self[PW-1:0];
            out_use_reg   <= use_dec;
            out_col_reg   <= s1_col_reg;
            out_row_reg   <= s1_drow_reg;
            out_end_reg   <= s1_ctl_reg.frame_end;
        end
    end

    assign decisions.valid         = out_valid_reg;
    assign decisions.low_res_index = out_index_reg;
    assign decisions.use_low_res   = out_use_reg;
    assign decisions.column        = out_col_reg;
    assign decisions.row           = out_row_reg;
    assign decisions.frame_end     = out_end_reg;

`ifndef NO_ASSERTIONS
    // column counter stays inside the configured viewport
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_count_reg) < w_reg)
        else $error("column counter outside viewport");

    // row counter never passes the configured height
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= h_reg)
        else $error("row counter past viewport height");

    // frame end is only flagged on the last column
    a_frame_end_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> (WW'(out_col_reg) + WW'(1) == w_reg))
        else $error("frame end away from last column");
`endif

endmodule
